// ===== rtl/core/aesd_pkg.sv =====
// Package for the AES-128 decryption core: sizes, register indexes and
// the GF(2^8) and inverse S-box helpers. Depends on nothing.
`timescale 1ns / 1ps
package aesd_pkg;
  localparam int unsigned NumRounds = 10;
  localparam int unsigned HalfW = 64;
  localparam int unsigned BlockW = 128;
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegKeyHigh = 1'b0;
  localparam logic [CfgIdxW-1:0] RegKeyLow = 1'b1;

  typedef logic [BlockW-1:0] block_t;

  typedef struct packed {
    logic [HalfW-1:0] hi;
    logic [HalfW-1:0] lo;
  } word_t;

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] x;
    logic [7:0] p;
    x = a;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = xt(x);
    end
    gmul = p;
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] v);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    sbox = t[v];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] v);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    inv_sbox = t[v];
  endfunction

  // Byte i of the block sits in bits 127-8i down to 120-8i.
  function automatic logic [7:0] byte_at(input block_t s, input int i);
    byte_at = s[BlockW-1-8*i -: 8];
  endfunction

  function automatic block_t inv_shift_sub(input block_t s);
    block_t t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[BlockW-1-8*(r+4*c) -: 8] = inv_sbox(byte_at(s, r + 4*((c - r + 4) % 4)));
      end
    end
    inv_shift_sub = t;
  endfunction

  function automatic block_t inv_mix(input block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = byte_at(s, 4*c);
      a1 = byte_at(s, 4*c+1);
      a2 = byte_at(s, 4*c+2);
      a3 = byte_at(s, 4*c+3);
      t[BlockW-1-32*c -: 8] = gmul(a0, 8'd14) ^ gmul(a1, 8'd11) ^ gmul(a2, 8'd13) ^ gmul(a3, 8'd9);
      t[BlockW-9-32*c -: 8] = gmul(a0, 8'd9) ^ gmul(a1, 8'd14) ^ gmul(a2, 8'd11) ^ gmul(a3, 8'd13);
      t[BlockW-17-32*c -: 8] = gmul(a0, 8'd13) ^ gmul(a1, 8'd9) ^ gmul(a2, 8'd14) ^ gmul(a3, 8'd11);
      t[BlockW-25-32*c -: 8] = gmul(a0, 8'd11) ^ gmul(a1, 8'd13) ^ gmul(a2, 8'd9) ^ gmul(a3, 8'd14);
    end
    inv_mix = t;
  endfunction

  // One step of the key schedule: round key n+1 from round key n.
  function automatic block_t next_key(input block_t k, input logic [7:0] rcon);
    logic [31:0] t;
    block_t o;
    t = {sbox(k[23:16]) ^ rcon, sbox(k[15:8]), sbox(k[7:0]), sbox(k[31:24])};
    o[127:96] = k[127:96] ^ t;
    o[95:64] = k[95:64] ^ o[127:96];
    o[63:32] = k[63:32] ^ o[95:64];
    o[31:0] = k[31:0] ^ o[63:32];
    next_key = o;
  endfunction
endpackage

// ===== rtl/core/aesd_if.sv =====
// Valid/ready channel carrying one 128-bit word as two halves.
// Depends on aesd_pkg.
`timescale 1ns / 1ps
interface aesd_if;
  import aesd_pkg::*;
  logic valid;
  logic ready;
  logic [HalfW-1:0] data_high;
  logic [HalfW-1:0] data_low;
  modport source (output valid, output data_high, output data_low, input ready);
  modport sink (input valid, input data_high, input data_low, output ready);
endinterface

// ===== rtl/core/aesd_key_sched.sv =====
// Key schedule: holds the key and a chain of eleven round key registers,
// one expansion step per stage. Depends on aesd_pkg.
`timescale 1ns / 1ps
module aesd_key_sched
  import aesd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CfgIdxW-1:0]   cfg_idx,
  input  logic [HalfW-1:0]     cfg_data,
  output block_t               rk [NumRounds+1],
  output logic                 busy
);
  localparam int unsigned SettleW = $clog2(NumRounds + 1);

  logic [7:0] rcon [NumRounds];
  block_t rk_r [NumRounds+1];
  logic [SettleW-1:0] settle_r;

  assign rcon = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

  // Each round key settles in the cycle after the one before it; busy stays
  // high until the last one has settled after a reset or a key write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rk_r[0] <= '0;
      settle_r <= SettleW'(NumRounds);
    end else if (cfg_we) begin
      case (cfg_idx)
        RegKeyHigh: rk_r[0][127:64] <= cfg_data;
        RegKeyLow:  rk_r[0][63:0] <= cfg_data;
        default:    rk_r[0] <= rk_r[0];
      endcase
      settle_r <= SettleW'(NumRounds);
    end else if (settle_r != '0) begin
      settle_r <= settle_r - SettleW'(1);
    end
    for (int i = 0; i < NumRounds; i++) begin
      rk_r[i+1] <= next_key(rk_r[i], rcon[i]);
    end
  end

  assign rk = rk_r;
  assign busy = (settle_r != '0);
endmodule

// ===== rtl/core/aesd_round.sv =====
// One inverse round stage with its valid bit and stall.
// Depends on aesd_pkg.
`timescale 1ns / 1ps
module aesd_round
  import aesd_pkg::*;
#(
  parameter bit First = 1'b0
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  logic   vld_in,
  input  block_t d_in,
  input  block_t key,
  output logic   vld_out,
  output block_t d_out
);
  logic   vld_r;
  block_t d_r;
  block_t d_nxt;

  always_comb begin
    if (First) begin
      d_nxt = inv_shift_sub(d_in ^ key);
    end else begin
      d_nxt = inv_shift_sub(inv_mix(d_in ^ key));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
    if (en) d_r <= d_nxt;
  end

  assign vld_out = vld_r;
  assign d_out = d_r;
endmodule

// ===== rtl/core/aes128_block_decrypt.sv =====
// AES-128 ECB decryption core, top level: ten round stages and an output
// register. Depends on aesd_pkg, aesd_if, aesd_key_sched and aesd_round.
//
// A ciphertext word enters on in_ (valid/ready) and the plaintext word
// leaves on out_. The key is written through cfg_ (index 0 key_high,
// index 1 key_low); write it only while the core is empty. While the
// write enable is high or the key schedule is busy in_ready stays low so
// the round keys settle; the next word then uses the new key. A word passes
// ten round stages and one output stage; a round stage is one table lookup
// plus inverse mix columns deep (none in the first), and the output stage
// adds round key 0. Throughput is one word per cycle while no key is
// settling; the whole pipeline advances as one whenever the output stage is
// empty or being taken. When the receiver stalls the pipeline holds,
// in_ready drops, and no word is lost or repeated. Reset clears every valid
// bit and loads the all-zero key; in_ready stays low while its keys settle.
`timescale 1ns / 1ps
module aes128_block_decrypt
  import aesd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  aesd_if.sink               in_ch,
  aesd_if.source             out_ch,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_idx,
  input  logic [HalfW-1:0]   cfg_data
);
  block_t rk [NumRounds+1];
  logic   vld [NumRounds+1];
  block_t st [NumRounds+1];
  logic   en;
  logic   key_busy;
  logic   out_vld_r;
  block_t out_r;

  aesd_key_sched u_keys (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_data, .rk, .busy(key_busy)
  );

  assign en = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en && !key_busy && !cfg_we;
  assign vld[0] = in_ch.valid && in_ch.ready;
  assign st[0] = {in_ch.data_high, in_ch.data_low};

  for (genvar g = 0; g < NumRounds; g++) begin : g_rnd
    aesd_round #(.First(g == 0)) u_rnd (
      .clk, .rst_n, .en,
      .vld_in(vld[g]), .d_in(st[g]), .key(rk[NumRounds-g]),
      .vld_out(vld[g+1]), .d_out(st[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld[NumRounds];
    end
    if (en) out_r <= st[NumRounds] ^ rk[0];
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data_high = out_r[127:64];
  assign out_ch.data_low = out_r[63:0];
endmodule

// ===== bench/aes128_block_decrypt_tb.sv =====
// Testbench for the AES-128 ECB decryption core: drives ciphertext words,
// predicts the plaintext with its own inverse cipher and key schedule.
// Depends on aesd_pkg, aesd_if and aes128_block_decrypt.
`timescale 1ns / 1ps
module aes128_block_decrypt_tb;
  import aesd_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = RegKeyHigh;
  logic [HalfW-1:0] cfg_data = '0;

  aesd_if in_ch();
  aesd_if out_ch();

  aes128_block_decrypt dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [HalfW-1:0] key_hi_m, key_lo_m;
  logic [127:0] rkeys [11];
  logic [7:0] sb_tab [256];
  logic [7:0] isb_tab [256];

  word_t cipher_q[$];
  word_t plain_exp_q[$];
  int errors = 0;
  int mismatches = 0;
  bit calm = 1'b0;
  bit recv_hold = 1'b0;
  bit send_hold = 1'b0;
  bit in_taken = 1'b0;
  int unsigned cycles = 0;

  function automatic logic [7:0] mul8(logic [7:0] a, logic [7:0] b);
    logic [8:0] x;
    logic [7:0] p;
    x = {1'b0, a};
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x[7:0];
      x = x << 1;
      if (x[8]) x = x ^ 9'h11b;
    end
    return p;
  endfunction

  function automatic logic [7:0] inv8(logic [7:0] a);
    logic [7:0] r, b;
    r = 8'h01;
    b = a;
    for (int e = 254; e != 0; e = e >> 1) begin
      if (e & 1) r = mul8(r, b);
      b = mul8(b, b);
    end
    return (a == 8'h00) ? 8'h00 : r;
  endfunction

  function automatic logic [7:0] rl8(logic [7:0] v, int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  task automatic build_tables();
    logic [7:0] b;
    for (int v = 0; v < 256; v++) begin
      b = inv8(v[7:0]);
      sb_tab[v] = b ^ rl8(b, 1) ^ rl8(b, 2) ^ rl8(b, 3) ^ rl8(b, 4) ^ 8'h63;
      isb_tab[v] = inv8(rl8(v[7:0], 1) ^ rl8(v[7:0], 3) ^ rl8(v[7:0], 6) ^ 8'h05);
    end
  endtask

  task automatic expand_keys();
    logic [7:0] w [44][4];
    logic [7:0] t [4];
    logic [7:0] tmp, rc;
    logic [127:0] k;
    k = {key_hi_m, key_lo_m};
    rc = 8'h01;
    for (int i = 0; i < 16; i++) w[i/4][i%4] = k[127-8*i -: 8];
    for (int i = 4; i < 44; i++) begin
      for (int j = 0; j < 4; j++) t[j] = w[i-1][j];
      if (i % 4 == 0) begin
        tmp = t[0]; t[0] = t[1]; t[1] = t[2]; t[2] = t[3]; t[3] = tmp;
        for (int j = 0; j < 4; j++) t[j] = sb_tab[t[j]];
        t[0] = t[0] ^ rc;
        rc = mul8(rc, 8'h02);
      end
      for (int j = 0; j < 4; j++) w[i][j] = w[i-4][j] ^ t[j];
    end
    for (int r = 0; r < 11; r++)
      for (int j = 0; j < 16; j++) rkeys[r][127-8*j -: 8] = w[4*r + j/4][j%4];
  endtask

  function automatic logic [127:0] unshift_unsub(logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127-8*(r+4*c) -: 8] = isb_tab[s[127-8*(r+4*((c-r+4)%4)) -: 8]];
    return t;
  endfunction

  function automatic logic [127:0] unmix(logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a [4];
    logic [7:0] m [4];
    m = '{8'd14, 8'd11, 8'd13, 8'd9};
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) a[j] = s[127-8*(4*c+j) -: 8];
      for (int row = 0; row < 4; row++)
        t[127-8*(4*c+row) -: 8] = mul8(a[0], m[(0-row+4)%4]) ^ mul8(a[1], m[(1-row+4)%4])
          ^ mul8(a[2], m[(2-row+4)%4]) ^ mul8(a[3], m[(3-row+4)%4]);
    end
    return t;
  endfunction

  function automatic word_t decrypt_block(word_t c);
    logic [127:0] s;
    word_t p;
    s = {c.hi, c.lo} ^ rkeys[10];
    s = unshift_unsub(s);
    for (int r = 9; r >= 1; r--) s = unshift_unsub(unmix(s ^ rkeys[r]));
    s = s ^ rkeys[0];
    p.hi = s[127:64];
    p.lo = s[63:0];
    return p;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic write_key(logic [CfgIdxW-1:0] idx, logic [HalfW-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == RegKeyHigh) key_hi_m = v;
    else key_lo_m = v;
    expand_keys();
    repeat (14) @(negedge clk);
  endtask

  task automatic drain();
    while (cipher_q.size() != 0 || plain_exp_q.size() != 0) @(negedge clk);
    repeat (14) @(negedge clk);
  endtask

  task automatic push_block(logic [63:0] h, logic [63:0] l);
    word_t w;
    w.hi = h;
    w.lo = l;
    cipher_q.push_back(w);
  endtask

  // Sender: feeds words from the pending queue with random idle bursts.
  int send_gap = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_taken) begin
    end else begin
      if (in_ch.valid) void'(cipher_q.pop_front());
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        send_gap <= $urandom_range(0, 17);
        in_ch.valid <= 1'b0;
      end else if (!send_hold && cipher_q.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.data_high <= cipher_q[0].hi;
        in_ch.data_low <= cipher_q[0].lo;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Prediction at acceptance so that the key in force is the one used.
  always @(posedge clk) begin
    word_t c;
    in_taken = rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      c.hi = in_ch.data_high;
      c.lo = in_ch.data_low;
      plain_exp_q.push_back(decrypt_block(c));
    end
  end

  int recv_gap = 0;
  always @(negedge clk) begin
    if (!rst_n || recv_hold) begin
      out_ch.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 12) == 0) begin
      recv_gap <= $urandom_range(0, 17);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    word_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (plain_exp_q.size() == 0) begin
        errors++;
        if (mismatches < 10) $display("Unexpected word %h %h", out_ch.data_high,
          out_ch.data_low);
        mismatches++;
      end else begin
        e = plain_exp_q.pop_front();
        if (e.hi !== out_ch.data_high || e.lo !== out_ch.data_low) begin
          errors++;
          if (mismatches < 10)
            $display("Mismatch: expected %h %h, got %h %h", e.hi, e.lo,
              out_ch.data_high, out_ch.data_low);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_high = '0;
    in_ch.data_low = '0;
    out_ch.ready = 1'b0;
    build_tables();
    key_hi_m = '0;
    key_lo_m = '0;
    expand_keys();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    push_block('0, '0);
    push_block('1, '1);
    push_block('1, '0);
    push_block('0, '1);
    push_block(64'h8000000000000001, 64'h0123456789abcdef);
    drain();
    write_key(RegKeyHigh, 64'h0001020304050607);
    write_key(RegKeyLow, 64'h08090a0b0c0d0e0f);
    push_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    push_block('0, '0);
    push_block('1, '1);
    push_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    drain();
    write_key(RegKeyHigh, '1);
    write_key(RegKeyLow, '1);
    push_block('0, '0);
    push_block('1, '1);
    push_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    drain();
    // Receiver holds off while the sender keeps offering.
    recv_hold = 1'b1;
    for (int i = 0; i < 40; i++) push_block(rand64(), rand64());
    repeat (80) @(negedge clk);
    recv_hold = 1'b0;
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      write_key(RegKeyHigh, (ph == 0) ? 64'h0 : rand64());
      write_key(RegKeyLow, (ph == 1) ? 64'h0 : rand64());
      if (ph == 5) calm = 1'b1;
      for (int i = 0; i < 170; i++) push_block(rand64(), rand64());
      if (ph == 2) begin
        while (cipher_q.size() > 85) @(negedge clk);
        send_hold = 1'b1;
        while (plain_exp_q.size() != 0) @(negedge clk);
        send_hold = 1'b0;
      end
      drain();
    end
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/aesd_pkg.sv
rtl/core/aesd_if.sv
rtl/core/aesd_key_sched.sv
rtl/core/aesd_round.sv
rtl/core/aes128_block_decrypt.sv
bench/aes128_block_decrypt_tb.sv
